[src/stup_pkg.sv]
// ----------------------------------------------------------------------------
// String-to-unsigned parser package
// Shared types, constants and the character classifier used by the front
// end, the word queue and the back end.
// ----------------------------------------------------------------------------
package stup_pkg;

	// Width of the converted value and of the multiply-add result
	localparam int VALUE_W = 64;
	localparam int RADIX_W = 6;
	localparam int MAC_W   = VALUE_W + RADIX_W + 1;

	// Queue depth between front and back
	localparam int QDEPTH  = 4;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// Radix codes
	localparam logic [RADIX_W-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_W-1:0] RADIX_BIN  = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_OCT  = 6'd8;
	localparam logic [RADIX_W-1:0] RADIX_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_HEX  = 6'd16;
	localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;

	// Digit value for a byte that is no digit in any radix
	localparam logic [RADIX_W-1:0] DIG_NONE   = 6'd63;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UB    = 8'h42;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// Parser phase
	typedef enum logic [2:0] {
		PH_WS,
		PH_SIGN,
		PH_ZERO,
		PH_DIG,
		PH_DONE,
		PH_BAD
	} phase_t;

	// Result status
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_BAD_RADIX = 2'd2
	} status_t;

	// Classified word as it travels from front to back
	typedef struct packed {
		logic [RADIX_W-1:0] dig;       // digit value, DIG_NONE if none
		logic [RADIX_W-1:0] radix;     // radix register at acceptance
		logic               radix_bad; // radix above 36
		logic               is_nul;
		logic               is_space;
		logic               is_minus;
		logic               is_plus;
		logic               is_zero;
		logic               is_x;
		logic               is_b;
		logic               last;
	} cls_t;

	// Classify one character
	function automatic cls_t classify(input logic [7:0] ch, input logic lst,
		input logic [RADIX_W-1:0] rdx);
		cls_t c;
		logic [7:0] d8;
		c  = '0;
		d8 = 8'hFF;
		if (ch >= CH_0 && ch <= CH_9)
			d8 = ch - CH_0;
		else if (ch >= CH_LA && ch <= CH_LZ)
			d8 = ch - CH_LA + 8'd10;
		else if (ch >= CH_UA && ch <= CH_UZ)
			d8 = ch - CH_UA + 8'd10;
		c.dig       = (d8 == 8'hFF) ? DIG_NONE : d8[RADIX_W-1:0];
		c.radix     = rdx;
		c.radix_bad = rdx > RADIX_MAX;
		c.is_nul    = ch == CH_NUL;
		c.is_space  = ch == CH_SPACE || ch == CH_FF || ch == CH_LF ||
			ch == CH_CR || ch == CH_TAB || ch == CH_VT;
		c.is_minus  = ch == CH_MINUS;
		c.is_plus   = ch == CH_PLUS;
		c.is_zero   = ch == CH_0;
		c.is_x      = ch == CH_LX || ch == CH_UX;
		c.is_b      = ch == CH_LB || ch == CH_UB;
		c.last      = lst;
		return c;
	endfunction

endpackage

[src/string_to_unsigned_parser.sv]
// ----------------------------------------------------------------------------
// String-to-unsigned parser
// Converts a character stream, one word per character, to an unsigned
// value with white-space skip, sign, radix prefix and overflow detection.
// ----------------------------------------------------------------------------
// Path: a last word passes the front stage, the word queue and the result
// register. Throughput: one word per cycle while char_stall is low; the
// 64 by 6 multiply-add of the digit accumulate sets the cycle.
// Reset: arst_n clears the parse state, the queue and the result valid; the
// radix register returns to 0 (automatic radix).
module string_to_unsigned_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [stup_pkg::RADIX_W-1:0] cfg_wdata,
	input  logic [7:0]                   character,
	input  logic                         last,
	input  logic                         char_valid,
	output logic                         char_stall,
	output logic [63:0]                  value,
	output logic [1:0]                   status,
	output logic                         result_valid,
	input  logic                         result_stall
);

	logic [stup_pkg::RADIX_W-1:0] radix_q;
	stup_pkg::cls_t               push_word;
	stup_pkg::cls_t               head;
	logic                         push_valid;
	logic                         queue_full;
	logic                         head_valid;
	logic                         pop;

	// Radix register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			radix_q <= stup_pkg::RADIX_AUTO;
		else if (cfg_we)
			radix_q <= cfg_wdata;
	end

	stup_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.character  (character),
		.last       (last),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.radix      (radix_q),
		.push_word  (push_word),
		.push_valid (push_valid),
		.queue_full (queue_full)
	);

	stup_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push_valid),
		.push_word  (push_word),
		.full       (queue_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	stup_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.value        (value),
		.status       (status),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

endmodule

[src/stup_front.sv]
// ----------------------------------------------------------------------------
// String-to-unsigned parser front end
// Takes character words, classifies them and holds them in one register
// stage until the queue has room.
// ----------------------------------------------------------------------------
module stup_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [7:0]                    character,
	input  logic                          last,
	input  logic                          char_valid,
	output logic                          char_stall,
	input  logic [stup_pkg::RADIX_W-1:0]  radix,
	output stup_pkg::cls_t                push_word,
	output logic                          push_valid,
	input  logic                          queue_full
);

	logic           valid_s1;
	stup_pkg::cls_t cls_s1;
	logic           load;
	logic           push;

	// Stage moves on when the queue takes it
	assign push       = valid_s1 && !queue_full;
	assign char_stall = valid_s1 && queue_full;
	assign load       = char_valid && !char_stall;

	// Stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load)
			valid_s1 <= 1'b1;
		else if (push)
			valid_s1 <= 1'b0;
	end

	// Classified word
	always_ff @(posedge clk) begin
		if (load)
			cls_s1 <= stup_pkg::classify(character, last, radix);
	end

	assign push_word  = cls_s1;
	assign push_valid = push;

endmodule

[src/stup_queue.sv]
// ----------------------------------------------------------------------------
// String-to-unsigned parser word queue
// Small FIFO of classified words between front and back end.
// ----------------------------------------------------------------------------
module stup_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stup_pkg::cls_t push_word,
	output logic           full,
	input  logic           pop,
	output stup_pkg::cls_t head,
	output logic           head_valid
);

	stup_pkg::cls_t                   mem_q [stup_pkg::QDEPTH];
	logic [stup_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [stup_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [stup_pkg::QCNT_W-1:0]      count_q;

	assign full       = count_q == stup_pkg::QCNT_W'(stup_pkg::QDEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_word;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// Never beyond depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= stup_pkg::QCNT_W'(stup_pkg::QDEPTH))
		else $error("queue count beyond depth");

endmodule

[src/stup_back.sv]
// ----------------------------------------------------------------------------
// String-to-unsigned parser back end
// Runs the parse state machine on queued words, accumulates digits with an
// exact overflow check and holds the result for the output side.
// ----------------------------------------------------------------------------
module stup_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  stup_pkg::cls_t       head,
	input  logic                 head_valid,
	output logic                 pop,
	output logic [63:0]          value,
	output logic [1:0]           status,
	output logic                 result_valid,
	input  logic                 result_stall
);

	localparam int VW = stup_pkg::VALUE_W;
	localparam int MW = stup_pkg::MAC_W;
	localparam int RW = stup_pkg::RADIX_W;

	stup_pkg::phase_t  phase_q, phase_n;
	logic              neg_q, neg_n;
	logic [VW-1:0]     acc_q, acc_n;
	logic [RW-1:0]     wr_q, wr_n;
	logic              rerr_q, rerr_n;

	logic              dig_en;
	logic [RW-1:0]     dig_r;
	logic [MW-1:0]     mac;
	logic              ovf;

	logic              out_valid_q;
	logic [VW-1:0]     res_acc_q;
	logic              res_neg_q;
	stup_pkg::status_t res_status_q;
	stup_pkg::status_t st_n;
	logic [VW-1:0]     res_val;

	// A last word needs the result register free
	assign pop = head_valid && (!head.last || !out_valid_q || !result_stall);

	// Next state, prefix handling and digit multiply-add
	always_comb begin
		phase_n = phase_q;
		neg_n   = neg_q;
		acc_n   = acc_q;
		wr_n    = wr_q;
		rerr_n  = rerr_q;
		dig_en  = 1'b0;
		dig_r   = wr_q;
		unique case (phase_q)
			stup_pkg::PH_WS: begin
				wr_n = head.radix;
				if (head.radix_bad)
					phase_n = stup_pkg::PH_BAD;
				else if (head.is_nul)
					phase_n = stup_pkg::PH_DONE;
				else if (head.is_space)
					phase_n = stup_pkg::PH_WS;
				else if (head.is_minus) begin
					neg_n   = 1'b1;
					phase_n = stup_pkg::PH_SIGN;
				end else if (head.is_plus)
					phase_n = stup_pkg::PH_SIGN;
				else if (head.is_zero && (head.radix == stup_pkg::RADIX_AUTO ||
					head.radix == stup_pkg::RADIX_HEX ||
					head.radix == stup_pkg::RADIX_BIN))
					phase_n = stup_pkg::PH_ZERO;
				else begin
					dig_en = 1'b1;
					dig_r  = (head.radix == stup_pkg::RADIX_AUTO) ?
						stup_pkg::RADIX_DEC : head.radix;
				end
			end
			stup_pkg::PH_SIGN: begin
				if (head.is_zero && (wr_q == stup_pkg::RADIX_AUTO ||
					wr_q == stup_pkg::RADIX_HEX || wr_q == stup_pkg::RADIX_BIN))
					phase_n = stup_pkg::PH_ZERO;
				else begin
					dig_en = 1'b1;
					dig_r  = (wr_q == stup_pkg::RADIX_AUTO) ?
						stup_pkg::RADIX_DEC : wr_q;
				end
			end
			stup_pkg::PH_ZERO: begin
				if (head.is_x) begin
					if (wr_q == stup_pkg::RADIX_BIN)
						phase_n = stup_pkg::PH_DONE;
					else begin
						wr_n    = stup_pkg::RADIX_HEX;
						phase_n = stup_pkg::PH_DIG;
					end
				end else if (head.is_b) begin
					if (wr_q == stup_pkg::RADIX_HEX)
						phase_n = stup_pkg::PH_DONE;
					else begin
						wr_n    = stup_pkg::RADIX_BIN;
						phase_n = stup_pkg::PH_DIG;
					end
				end else begin
					dig_en = 1'b1;
					dig_r  = (wr_q == stup_pkg::RADIX_AUTO) ?
						stup_pkg::RADIX_OCT : wr_q;
				end
			end
			stup_pkg::PH_DIG: begin
				dig_en = 1'b1;
			end
			stup_pkg::PH_DONE, stup_pkg::PH_BAD: begin
				phase_n = phase_q;
			end
			default: begin
				phase_n = stup_pkg::PH_DONE;
			end
		endcase

		// acc * r + d; anything above the value width is an overflow
		mac = MW'(acc_q) * MW'(dig_r) + MW'(head.dig);
		ovf = |mac[MW-1:VW];

		if (dig_en) begin
			wr_n    = dig_r;
			phase_n = stup_pkg::PH_DIG;
			if (head.is_nul || head.dig >= dig_r)
				phase_n = stup_pkg::PH_DONE;
			else if (ovf) begin
				acc_n   = '1;
				rerr_n  = 1'b1;
				phase_n = stup_pkg::PH_DONE;
			end else
				acc_n = mac[VW-1:0];
		end

		if (phase_n == stup_pkg::PH_BAD)
			st_n = stup_pkg::ST_BAD_RADIX;
		else if (rerr_n)
			st_n = stup_pkg::ST_RANGE;
		else
			st_n = stup_pkg::ST_OK;
	end

	// Parse state; cleared after each result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= stup_pkg::PH_WS;
			neg_q   <= 1'b0;
			acc_q   <= '0;
			wr_q    <= '0;
			rerr_q  <= 1'b0;
		end else if (pop) begin
			if (head.last) begin
				phase_q <= stup_pkg::PH_WS;
				neg_q   <= 1'b0;
				acc_q   <= '0;
				wr_q    <= '0;
				rerr_q  <= 1'b0;
			end else begin
				phase_q <= phase_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				wr_q    <= wr_n;
				rerr_q  <= rerr_n;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (pop && head.last)
			out_valid_q <= 1'b1;
		else if (!result_stall)
			out_valid_q <= 1'b0;
	end

	// Result payload; errors carry all ones and no sign
	always_ff @(posedge clk) begin
		if (pop && head.last) begin
			res_status_q <= st_n;
			res_acc_q    <= (st_n == stup_pkg::ST_OK) ? acc_n : '1;
			res_neg_q    <= (st_n == stup_pkg::ST_OK) && neg_n;
		end
	end

	assign res_val      = res_neg_q ? (VW'(0) - res_acc_q) : res_acc_q;
	assign value        = 64'(res_val);
	assign status       = 2'(res_status_q);
	assign result_valid = out_valid_q;

	// State is fresh after every result
	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.last |=> phase_q == stup_pkg::PH_WS && acc_q == '0 && !neg_q)
		else $error("state not cleared after result");

	// A range error always leaves a saturated accumulator
	a_sat_on_range: assert property (@(posedge clk) disable iff (!arst_n)
		rerr_q |-> acc_q == '1 && phase_q == stup_pkg::PH_DONE)
		else $error("range error without saturation");

	// Digits only accumulate under a usable radix
	a_dig_radix: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == stup_pkg::PH_DIG |-> wr_q != '0 && wr_q <= stup_pkg::RADIX_MAX)
		else $error("digit phase with unusable radix");

endmodule
